FILE: src/rxfw_pkg.sv
// ----------------------------------------------------------------------------
// rxfw_pkg: shared types and constants of the receive FIFO
// Holds the request codes, the configuration register indexes, the constants of
// the divide-by-three watermark arithmetic and the control struct that the
// top level hands to the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rxfw_pkg;

  // Physical depth of the byte chain when the top level is not told otherwise.
  localparam int DEPTH_DEFAULT = 256;

  // Width of the byte payload and of the reported fill count.
  localparam int BYTE_W = 8;
  localparam int FILL_W = 9;
  localparam int CAP_W  = 9;

  // Request codes carried by req_type. Code 3 carries no meaning.
  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2
  } rxfw_req_t;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY   = 1'b0;
  localparam logic CFG_RTS_ENABLE = 1'b1;

  // floor(x / 3) equals (x * Recip3) >> Recip3Shift for every x below 2048,
  // which covers twice the largest capacity.
  localparam int Recip3      = 683;
  localparam int Recip3Shift = 11;
  localparam int PROD_W      = 20;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } rxfw_op_t;

endpackage

`default_nettype wire

FILE: src/rxfw_cell.sv
// ----------------------------------------------------------------------------
// rxfw_cell: one byte slot of the receive chain
// On a pop the slot takes the byte of its upper neighbor, so the oldest byte
// always sits in slot zero. On a push the slot whose index equals the fill
// count captures the incoming byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rxfw_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  wire logic                          clk,
  input  wire rxfw_pkg::rxfw_op_t            op,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic [rxfw_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic [rxfw_pkg::BYTE_W-1:0]   up_byte,
  output logic      [rxfw_pkg::BYTE_W-1:0]   byte_q
);

  // Payload only, so no reset is needed.
  always_ff @(posedge clk) begin
    if (op.pop) begin
      byte_q <= up_byte;
    end else if (op.push && (count == CNT_W'(INDEX))) begin
      byte_q <= in_byte;
    end
  end

endmodule

`default_nettype wire

FILE: src/rxfw_chain.sv
// ----------------------------------------------------------------------------
// rxfw_chain: row of byte slots forming the FIFO storage
// Slots hand their bytes down by one place on every pop; the head byte is
// always read from slot zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rxfw_chain #(
  parameter int DEPTH = rxfw_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire rxfw_pkg::rxfw_op_t            op,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic [rxfw_pkg::BYTE_W-1:0]   in_byte,
  output logic      [rxfw_pkg::BYTE_W-1:0]   head_byte
);

  logic [rxfw_pkg::BYTE_W-1:0] slot_byte [DEPTH];
  logic [rxfw_pkg::BYTE_W-1:0] slot_up   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    // The top slot has no neighbor; what it takes on a pop is never read.
    if (i == DEPTH - 1) begin : g_top
      assign slot_up[i] = '0;
    end else begin : g_mid
      assign slot_up[i] = slot_byte[i+1];
    end

    rxfw_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .count   (count),
      .in_byte (in_byte),
      .up_byte (slot_up[i]),
      .byte_q  (slot_byte[i])
    );
  end

  assign head_byte = slot_byte[0];

endmodule

`default_nettype wire

FILE: src/uart_rx_fifo_rts_watermark_top.sv
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_watermark_top: serial receive FIFO with RTS watermarks
// Byte FIFO built as a chain of shifting slots, with a sticky overflow flag
// and RTS flow control raised and lowered at two thirds and one third of the
// configured capacity.
//
//   Channel   Handshake            Payload
//   --------  -------------------  -----------------------------------------
//   request   start & !busy        req_type, rx_byte
//   result    done (one cycle)     read_data, read_empty, fill_count,
//                                  overflow_flag, rts_level
//   config    cfg_we               cfg_index, cfg_data
//
// The result of an accepted item is registered and shown with done in the
// following cycle, and a new item may be accepted at every edge, because the
// whole update (fill compare, watermark compare and one shift or write in the
// slot chain) is combinational and registered at the accepting edge. busy is
// therefore never raised. The receiver cannot stall, so nothing ever waits.
// Reset clears the internal fill count, overflow and RTS state, done and both
// configuration registers at once; the result registers and byte slots are
// not cleared, and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx_fifo_rts_watermark_top #(
  parameter int DEPTH = rxfw_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request side.
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    req_type,
  input  wire logic [rxfw_pkg::BYTE_W-1:0]   rx_byte,
  // Result side.
  output logic                               done,
  output logic      [rxfw_pkg::BYTE_W-1:0]   read_data,
  output logic                               read_empty,
  output logic      [rxfw_pkg::FILL_W-1:0]   fill_count,
  output logic                               overflow_flag,
  output logic                               rts_level,
  // Configuration write port.
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [rxfw_pkg::CAP_W-1:0]    cfg_data
);

  // The count has to hold DEPTH itself; comparisons use a width that fits both
  // the count and the 9-bit capacity.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > rxfw_pkg::CAP_W) ? CNT_W : rxfw_pkg::CAP_W;

  // Configuration registers.
  logic [rxfw_pkg::CAP_W-1:0] capacity_limit;
  logic                       rts_enable;

  // Control state.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             overflow_seen;
  logic             overflow_next;
  logic             rts_state;
  logic             rts_next;

  logic                        accept;
  rxfw_pkg::rxfw_req_t         req;
  rxfw_pkg::rxfw_op_t          op;
  logic [rxfw_pkg::BYTE_W-1:0] head_byte;

  // Limit and watermark arithmetic; limit and marks depend on configuration only.
  logic [CMP_W-1:0]           count_ext;
  logic [CMP_W-1:0]           next_ext;
  logic [CMP_W-1:0]           cap_ext;
  logic [CMP_W-1:0]           limit_ext;
  logic                       full;
  logic                       rts_active;
  logic [rxfw_pkg::PROD_W-1:0] hi_prod;
  logic [rxfw_pkg::PROD_W-1:0] lo_prod;
  logic [rxfw_pkg::CAP_W-1:0] hi_mark;
  logic [rxfw_pkg::CAP_W-1:0] lo_mark;

  // No item ever stalls the request side.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign req    = rxfw_pkg::rxfw_req_t'(req_type);

  assign count_ext = CMP_W'(count);
  assign next_ext  = CMP_W'(count_next);
  assign cap_ext   = CMP_W'(capacity_limit);

  // A capacity of zero, or one above the physical depth, leaves DEPTH as the
  // bound on the fill.
  assign limit_ext = ((capacity_limit == '0) || (cap_ext > CMP_W'(DEPTH)))
                     ? CMP_W'(DEPTH) : cap_ext;
  assign full       = count_ext >= limit_ext;
  assign rts_active = rts_enable && (capacity_limit != '0);

  // Raise mark is floor(2 * capacity / 3), lower mark floor(capacity / 3),
  // both taken by a reciprocal multiply.
  assign hi_prod = rxfw_pkg::PROD_W'({capacity_limit, 1'b0})
                   * rxfw_pkg::PROD_W'(rxfw_pkg::Recip3);
  assign lo_prod = rxfw_pkg::PROD_W'(capacity_limit)
                   * rxfw_pkg::PROD_W'(rxfw_pkg::Recip3);
  assign hi_mark = hi_prod[rxfw_pkg::Recip3Shift +: rxfw_pkg::CAP_W];
  assign lo_mark = lo_prod[rxfw_pkg::Recip3Shift +: rxfw_pkg::CAP_W];

  // Decode of the accepted item into at most one chain command and the next state.
  always_comb begin
    op            = '0;
    count_next    = count;
    overflow_next = overflow_seen;
    rts_next      = rts_state;
    if (accept) begin
      unique case (req)
        rxfw_pkg::REQ_PUSH: begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            op.push    = 1'b1;
            count_next = count + CNT_W'(1);
          end
          if (rts_active && (next_ext >= CMP_W'(hi_mark))) begin
            rts_next = 1'b1;
          end
        end
        rxfw_pkg::REQ_POP: begin
          if (count != '0) begin
            op.pop     = 1'b1;
            count_next = count - CNT_W'(1);
          end
          if (rts_active && (next_ext <= CMP_W'(lo_mark))) begin
            rts_next = 1'b0;
          end
        end
        rxfw_pkg::REQ_CLEAR: begin
          overflow_next = 1'b0;
        end
        default: begin
          // The unused code leaves the state as it is.
        end
      endcase
    end
  end

  rxfw_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk       (clk),
    .op        (op),
    .count     (count),
    .in_byte   (rx_byte),
    .head_byte (head_byte)
  );

  // Configuration registers and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= '0;
      rts_enable     <= 1'b0;
      count          <= '0;
      overflow_seen  <= 1'b0;
      rts_state      <= 1'b0;
      done           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rxfw_pkg::CFG_CAPACITY:   capacity_limit <= cfg_data;
          rxfw_pkg::CFG_RTS_ENABLE: rts_enable     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      count         <= count_next;
      overflow_seen <= overflow_next;
      rts_state     <= rts_next;
      done          <= accept;
    end
  end

  // Result registers. The popped byte is the head slot before the shift.
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data     <= op.pop ? head_byte : '0;
      read_empty    <= (req == rxfw_pkg::REQ_POP) && (count == '0);
      fill_count    <= rxfw_pkg::FILL_W'(count_next);
      overflow_flag <= overflow_next;
      rts_level     <= rts_next;
    end
  end

  // The fill never passes the physical depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  // Every accepted item gives exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result missing after an accepted item");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without an accepted item");

  // A read that found nothing reports an empty FIFO and no data.
  a_empty_read: assert property (@(posedge clk) disable iff (rst)
    (done && read_empty) |-> ((fill_count == '0) && (read_data == '0)))
    else $error("empty read with data or fill");

  // A push that finds the FIFO full leaves the overflow flag set.
  a_overflow_set: assert property (@(posedge clk) disable iff (rst)
    (accept && (req == rxfw_pkg::REQ_PUSH) && full) |=> overflow_seen)
    else $error("dropped byte did not set overflow");

endmodule

`default_nettype wire
